// ----- rtl/core/cpts_pkg.sv -----
// Shared constants, types and helpers for the clock polynomial time shift block.
// No dependencies; every other file in rtl/core imports this package.
package cpts_pkg;

    // Field widths
    localparam int COEF_W    = 48;
    localparam int DT_W      = 40;
    localparam int ORDER_W   = 3;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Polynomial size and fixed point scaling
    localparam int MAX_ORDER  = 5;
    localparam int NCOEF      = MAX_ORDER + 1;
    localparam int NUM_MACS   = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int FRAC_SHIFT = 16;

    // Default depth of the queue between front and back
    localparam int DEF_QUEUE_DEPTH = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx REG_COEF_LAST = t_cfg_idx'(NCOEF - 1);
    localparam t_cfg_idx REG_ORDER     = t_cfg_idx'(NCOEF);
    localparam t_cfg_idx REG_PRESENT   = t_cfg_idx'(NCOEF + 1);

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NCOEF-1:0]        t_coefs;

    // Clock model as held in the configuration registers
    typedef struct packed {
        t_coefs               coef;
        logic [ORDER_W-1:0]   order;
        logic                 present;
    } t_model;

    // Classified word travelling from front to back
    typedef struct packed {
        logic signed [DT_W-1:0] dt;
        logic                   err;
        logic [ORDER_W-1:0]     order;
    } t_item;

    // Working state of one word inside the multiply-add triangle
    typedef struct packed {
        t_coefs                 b;
        logic signed [DT_W-1:0] dt;
        logic                   err;
        logic [CNT_W-1:0]       cnt;
        logic                   ovf;
    } t_lane;

    // Coefficient index updated by multiply-add unit number mac_idx: passes of
    // falling length, each sweeping from the top coefficient downwards
    function automatic int mac_target(input int mac_idx);
        int rem;
        int pass_len;
        int res;
        rem      = mac_idx;
        pass_len = MAX_ORDER;
        res      = 0;
        for (int p = 0; p < MAX_ORDER; p++) begin
            if (rem >= 0 && rem < pass_len) begin
                res = MAX_ORDER - 1 - rem;
            end
            rem      = rem - pass_len;
            pass_len = pass_len - 1;
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/cpts_front.sv -----
// Front end: accepts time offsets and classifies them against the clock model.
// Depends on cpts_pkg; feeds cpts_queue.
module cpts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [cpts_pkg::DT_W-1:0] i_dt,
    output logic                          o_full,
    input  cpts_pkg::t_model              i_model,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output cpts_pkg::t_item               o_item
);
    import cpts_pkg::*;

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    t_item n_item;
    logic  w_move;
    logic  w_accept;

    // Hand the held word on whenever the queue has room
    assign w_move   = r_vld && !i_q_full;
    assign o_full   = r_vld && i_q_full;
    assign w_accept = i_push && !o_full;
    assign n_vld    = w_accept || (r_vld && !w_move);

    // Classify: missing model or unusable order is an error
    always_comb begin
        n_item.dt    = i_dt;
        n_item.order = i_model.order;
        n_item.err   = !i_model.present || (i_model.order > ORDER_W'(MAX_ORDER));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Hold the payload until the next word arrives
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_q_push = w_move;
    assign o_item   = r_item;

endmodule

// ----- rtl/core/cpts_queue.sv -----
// Small register queue parting the front end from the arithmetic back end.
// Depends on cpts_pkg for the word type.
module cpts_queue #(
    parameter int DEPTH = cpts_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpts_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output cpts_pkg::t_item o_item,
    output logic            o_empty
);
    import cpts_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    // Advance pointers with wrap at the last entry
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ----- rtl/core/cpts_mac.sv -----
// One multiply-add cell of the shift triangle: b[T] += round(b[T+1] * dt).
// Three stages: partial products, product sum with rounding, saturating add.
// Depends on cpts_pkg.
module cpts_mac #(
    parameter int TARGET = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_vld,
    input  cpts_pkg::t_lane i_lane,
    output logic            o_vld,
    output cpts_pkg::t_lane o_lane
);
    import cpts_pkg::*;

    localparam int BL_W   = COEF_W / 2;
    localparam int BH_W   = COEF_W - BL_W;
    localparam int DL_W   = DT_W / 2;
    localparam int DH_W   = DT_W - DL_W;
    localparam int HH_W   = BH_W + DH_W;
    localparam int HL_W   = BH_W + DL_W + 1;
    localparam int LH_W   = BL_W + 1 + DH_W;
    localparam int LL_W   = BL_W + DL_W + 2;
    localparam int PROD_W = COEF_W + DT_W;
    localparam int Q_W    = PROD_W - FRAC_SHIFT;

    localparam logic [PROD_W-1:0] ROUND   = PROD_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

    logic [2:0]               r_vld;
    t_lane                    r_lane1;
    t_lane                    r_lane2;
    t_lane                    r_lane3;
    t_lane                    n_lane3;

    logic [COEF_W-1:0]        w_bm;
    logic signed [BL_W:0]     w_bl;
    logic signed [BH_W-1:0]   w_bh;
    logic signed [DL_W:0]     w_dl;
    logic signed [DH_W-1:0]   w_dh;
    logic signed [HH_W-1:0]   n_pp_hh;
    logic signed [HL_W-1:0]   n_pp_hl;
    logic signed [LH_W-1:0]   n_pp_lh;
    logic signed [LL_W-1:0]   n_pp_ll;
    logic signed [HH_W-1:0]   r_pp_hh;
    logic signed [HL_W-1:0]   r_pp_hl;
    logic signed [LH_W-1:0]   r_pp_lh;
    logic signed [LL_W-1:0]   r_pp_ll;

    logic [PROD_W-1:0]        w_prod;
    logic [Q_W-1:0]           n_q;
    logic [Q_W-1:0]           r_q;

    logic                     w_q_ok;
    logic [COEF_W-1:0]        w_q_sat;
    logic [COEF_W-1:0]        w_b;
    logic [COEF_W:0]          w_acc;
    logic                     w_acc_ovf;
    logic [COEF_W-1:0]        w_res;

    // Stage 1: split both operands and form four partial products
    assign w_bm    = i_lane.b[TARGET + 1];
    assign w_bl    = {1'b0, w_bm[BL_W-1:0]};
    assign w_bh    = w_bm[COEF_W-1:BL_W];
    assign w_dl    = {1'b0, i_lane.dt[DL_W-1:0]};
    assign w_dh    = i_lane.dt[DT_W-1:DL_W];
    assign n_pp_hh = w_bh * w_dh;
    assign n_pp_hl = w_bh * w_dl;
    assign n_pp_lh = w_bl * w_dh;
    assign n_pp_ll = w_bl * w_dl;

    // Stage 2: weight and sum the partial products, round half up, drop fraction
    assign w_prod = ({{(PROD_W - HH_W){r_pp_hh[HH_W-1]}}, r_pp_hh} << (BL_W + DL_W))
                  + ({{(PROD_W - HL_W){r_pp_hl[HL_W-1]}}, r_pp_hl} << BL_W)
                  + ({{(PROD_W - LH_W){r_pp_lh[LH_W-1]}}, r_pp_lh} << DL_W)
                  + {{(PROD_W - LL_W){r_pp_ll[LL_W-1]}}, r_pp_ll}
                  + ROUND;
    assign n_q = w_prod[PROD_W-1:FRAC_SHIFT];

    // Stage 3: clamp the product, add, clamp the sum
    assign w_q_ok    = (&r_q[Q_W-1:COEF_W-1]) || !(|r_q[Q_W-1:COEF_W-1]);
    assign w_q_sat   = w_q_ok ? r_q[COEF_W-1:0] : (r_q[Q_W-1] ? SAT_MIN : SAT_MAX);
    assign w_b       = r_lane2.b[TARGET];
    assign w_acc     = {w_b[COEF_W-1], w_b} + {w_q_sat[COEF_W-1], w_q_sat};
    assign w_acc_ovf = (w_acc[COEF_W] != w_acc[COEF_W-1]);
    assign w_res     = w_acc_ovf ? (w_acc[COEF_W] ? SAT_MIN : SAT_MAX) : w_acc[COEF_W-1:0];

    always_comb begin
        n_lane3           = r_lane2;
        n_lane3.b[TARGET] = w_res;
        n_lane3.ovf       = r_lane2.ovf | !w_q_ok | w_acc_ovf;
    end

    // Advance the valid bits with the whole pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Payload stages, frozen while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane1 <= i_lane;
            r_pp_hh <= n_pp_hh;
            r_pp_hl <= n_pp_hl;
            r_pp_lh <= n_pp_lh;
            r_pp_ll <= n_pp_ll;
            r_lane2 <= r_lane1;
            r_q     <= n_q;
            r_lane3 <= n_lane3;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_lane = r_lane3;

endmodule

// ----- rtl/core/cpts_back.sv -----
// Back end: loads classified words, masks unused coefficients and runs them
// through the chain of multiply-add cells. Depends on cpts_pkg and cpts_mac.
module cpts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpts_pkg::t_model i_model,
    input  cpts_pkg::t_item  i_item,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_vld,
    output cpts_pkg::t_lane  o_lane
);
    import cpts_pkg::*;

    logic  w_adv;
    t_lane w_lane0;
    logic  w_vld  [NUM_MACS + 1];
    t_lane w_lane [NUM_MACS + 1];

    // Move the whole chain unless a finished word is waiting to be taken
    assign w_adv   = !w_vld[NUM_MACS] || i_pop;
    assign o_q_pop = w_adv && !i_q_empty;

    // Load the model: coefficients above the order and all on error read zero
    always_comb begin
        w_lane0     = '0;
        w_lane0.dt  = i_item.dt;
        w_lane0.err = i_item.err;
        w_lane0.cnt = i_item.err ? '0 : CNT_W'(i_item.order) + CNT_W'(1);
        for (int k = 0; k < NCOEF; k++) begin
            if (!i_item.err && (ORDER_W'(k) <= i_item.order)) begin
                w_lane0.b[k] = i_model.coef[k];
            end
        end
    end

    assign w_vld[0]  = !i_q_empty;
    assign w_lane[0] = w_lane0;

    // Triangle of multiply-add cells, pass by pass
    for (genvar gi = 0; gi < NUM_MACS; gi++) begin : g_mac
        cpts_mac #(
            .TARGET (mac_target(gi))
        ) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[gi]),
            .i_lane  (w_lane[gi]),
            .o_vld   (w_vld[gi + 1]),
            .o_lane  (w_lane[gi + 1])
        );
    end

    assign o_vld  = w_vld[NUM_MACS];
    assign o_lane = w_lane[NUM_MACS];

endmodule

// ----- rtl/core/clock_polynomial_time_shift.sv -----
// Clock polynomial time shift, top level: configuration registers, front end,
// queue and multiply-add back end. Depends on cpts_pkg and all cpts_* modules.
//
// Usage:
//  - Configuration: write registers 0..5 (coefficients, signed Q16.32), 6 (order)
//    and 7 (model present) on the cfg channel while no words are in flight;
//    o_cfg_ready is always high.
//  - Input: drive i_dt (signed Q24.16) and push; the word is taken at an edge
//    with push high and full low.
//  - Output: while empty is low the oldest result is on the o_ ports; pop takes it.
//  - Throughput: one word per cycle while results are popped, set by the fully
//    pipelined triangle of 15 multiply-add cells of three stages each.
//  - Stall: a result left waiting freezes the back end; the queue then fills
//    (QUEUE_DEPTH words plus one held in the front end) before full rises.
//  - Reset: all registers read zero (model missing) and every stage is emptied.
module clock_polynomial_time_shift #(
    parameter int QUEUE_DEPTH = cpts_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cpts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpts_pkg::COEF_W-1:0]        i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [cpts_pkg::DT_W-1:0]   i_dt,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c0,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c1,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c2,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c3,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c4,
    output logic signed [cpts_pkg::COEF_W-1:0] o_shifted_c5,
    output logic [cpts_pkg::CNT_W-1:0]         o_term_count,
    output logic                               o_status,
    output logic                               o_overflow
);
    import cpts_pkg::*;

    t_coefs             r_coef;
    logic [ORDER_W-1:0] r_order;
    logic               r_present;
    t_model             w_model;
    logic               w_cfg_we;

    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;
    t_item              w_front_item;
    t_item              w_q_item;
    logic               w_out_vld;
    t_lane              w_out_lane;

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef    <= '0;
            r_order   <= '0;
            r_present <= 1'b0;
        end else if (w_cfg_we) begin
            if (i_cfg_index <= REG_COEF_LAST) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end else begin
                case (i_cfg_index)
                    REG_ORDER: begin
                        r_order <= i_cfg_data[ORDER_W-1:0];
                    end
                    REG_PRESENT: begin
                        r_present <= i_cfg_data[0];
                    end
                    default: begin
                        r_present <= r_present;
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_model.coef    = r_coef;
        w_model.order   = r_order;
        w_model.present = r_present;
    end

    cpts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_dt     (i_dt),
        .o_full   (full),
        .i_model  (w_model),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_item   (w_front_item)
    );

    cpts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty)
    );

    cpts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_model   (w_model),
        .i_item    (w_q_item),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_vld     (w_out_vld),
        .o_lane    (w_out_lane)
    );

    // Present the finished word
    assign empty        = !w_out_vld;
    assign o_shifted_c0 = w_out_lane.b[0];
    assign o_shifted_c1 = w_out_lane.b[1];
    assign o_shifted_c2 = w_out_lane.b[2];
    assign o_shifted_c3 = w_out_lane.b[3];
    assign o_shifted_c4 = w_out_lane.b[4];
    assign o_shifted_c5 = w_out_lane.b[5];
    assign o_term_count = w_out_lane.cnt;
    assign o_status     = w_out_lane.err;
    assign o_overflow   = w_out_lane.ovf;

`ifndef NO_ASSERTIONS
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending right after reset");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_term_count == '0 && !o_overflow
            && o_shifted_c0 == '0 && o_shifted_c1 == '0 && o_shifted_c5 == '0))
        else $error("error result carries data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_status) |-> (o_term_count != '0
            && o_term_count <= CNT_W'(NCOEF)))
        else $error("term count out of range on good result");

    a_top_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_term_count < CNT_W'(NCOEF)) |-> (o_shifted_c5 == '0))
        else $error("coefficient above the order is not zero");
`endif

endmodule
